@@ sv/bab_pkg.sv @@
// Shared types, widths and codes of the block allocation bitmap.
// Depends on nothing; compiled first.
`default_nettype none

package bab_pkg;

    // Defaults of the top-level parameters
    localparam int unsigned MAX_BLOCKS_DEF     = 1024;
    localparam int unsigned SCAN_WORD_BITS_DEF = 32;

    // Field widths of the request and response
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned IDX_W    = 10;
    localparam int unsigned CNT_W    = 11;
    localparam int unsigned STATUS_W = 2;

    localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;
    localparam logic [CNT_W-1:0] CNT_SAT         = '1;

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Request kinds
    localparam kind_t KIND_FORMAT = 3'd0;
    localparam kind_t KIND_CHECK  = 3'd1;
    localparam kind_t KIND_ALLOC  = 3'd2;
    localparam kind_t KIND_FREE   = 3'd3;
    localparam kind_t KIND_FIND   = 3'd4;

    // Response status codes
    localparam status_t STAT_OK        = 2'd0;
    localparam status_t STAT_RANGE     = 2'd1;
    localparam status_t STAT_NOT_ALLOC = 2'd2;
    localparam status_t STAT_IN_USE    = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // latch the request
        logic decode;     // read the row of block_index
        logic range_err;  // report index out of range
        logic fmt_start;  // restore count and hint, restart the sweep
        logic clr_step;   // zero one map row
        logic examine;    // act on the row of block_index
        logic scan_init;  // start a free-block scan
        logic scan_step;  // evaluate one row, fetch the next
        logic load_out;   // move the result into the response register
    } bab_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_format;
        logic is_find;
        logic is_map_op;   // check, allocate or free
        logic range_bad;
        logic need_scan;
        logic scan_empty;
        logic scan_end;
        logic clr_last;
    } bab_stat_t;

endpackage

`default_nettype wire

@@ sv/bab_if.sv @@
// Request and response channels of the block allocation bitmap.
// Depends on bab_pkg for the field widths.
`default_nettype none

interface bab_req_if;
    logic                          valid;
    logic                          ready;
    logic [bab_pkg::KIND_W-1:0]    kind;
    logic [bab_pkg::IDX_W-1:0]     block_index;
    logic [bab_pkg::CNT_W-1:0]     search_start;

    modport source (output valid, output kind, output block_index, output search_start,
                    input ready);
    modport sink   (input valid, input kind, input block_index, input search_start,
                    output ready);
endinterface

interface bab_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bab_pkg::STATUS_W-1:0]  status;
    logic [bab_pkg::IDX_W-1:0]     found_block;
    logic                          found_valid;
    logic [bab_pkg::CNT_W-1:0]     free_total;
    logic [bab_pkg::IDX_W-1:0]     first_free_hint;
    logic                          hint_valid;

    modport source (output valid, output status, output found_block, output found_valid,
                    output free_total, output first_free_hint, output hint_valid,
                    input ready);
    modport sink   (input valid, input status, input found_block, input found_valid,
                    input free_total, input first_free_hint, input hint_valid,
                    output ready);
endinterface

`default_nettype wire

@@ sv/bab_datapath.sv @@
// Datapath of the block allocation bitmap: map memory, counters, hint, scan logic
// and response register. Depends on bab_pkg; driven by bab_ctrl.
`default_nettype none

module bab_datapath #(
    parameter int unsigned MAX_BLOCKS     = bab_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned SCAN_WORD_BITS = bab_pkg::SCAN_WORD_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [bab_pkg::CNT_W-1:0]    block_count,
    input  wire logic [bab_pkg::KIND_W-1:0]   req_kind,
    input  wire logic [bab_pkg::IDX_W-1:0]    req_block_index,
    input  wire logic [bab_pkg::CNT_W-1:0]    req_search_start,
    input  wire bab_pkg::bab_cmd_t            cmd,
    output bab_pkg::bab_stat_t                stat,
    output logic [bab_pkg::STATUS_W-1:0]      status,
    output logic [bab_pkg::IDX_W-1:0]         found_block,
    output logic                              found_valid,
    output logic [bab_pkg::CNT_W-1:0]         free_total,
    output logic [bab_pkg::IDX_W-1:0]         first_free_hint,
    output logic                              hint_valid
);
    import bab_pkg::*;

    // Map rows are a power of two wide so block -> (row, bit) is a shift and a mask
    localparam int unsigned LOG_W     = $clog2(SCAN_WORD_BITS);
    localparam int unsigned WORD_BITS = 1 << LOG_W;
    localparam int unsigned ROWS      = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned OFF_W     = (LOG_W > 0) ? LOG_W : 1;
    localparam int unsigned RST_FREE_I = (MAX_BLOCKS > 1024) ? 1024 : MAX_BLOCKS;
    localparam logic [CNT_W-1:0] RST_FREE  = CNT_W'(RST_FREE_I);
    localparam logic [CNT_W-1:0] OFF_MASK  = CNT_W'(WORD_BITS - 1);
    localparam logic [CNT_W-1:0] WORD_SPAN = CNT_W'(WORD_BITS);

    logic [WORD_BITS-1:0] map_mem [ROWS];
    logic [WORD_BITS-1:0] rdata_reg;

    logic [KIND_W-1:0]   kind_reg;
    logic [CNT_W-1:0]    idx_reg, start_reg, n_reg;
    logic [CNT_W-1:0]    free_reg, free_next;
    logic [CNT_W-1:0]    hint_reg, hint_next;
    logic                hint_ok_reg, hint_ok_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CNT_W-1:0]    found_reg, found_next;
    logic                fvalid_reg, fvalid_next;
    logic [ROW_W-1:0]    scan_row_reg, scan_row_next;
    logic                first_reg, first_next;
    logic [OFF_W-1:0]    off0_reg, off0_next;
    logic [ROW_W-1:0]    clr_row_reg, clr_row_next;

    logic [CNT_W-1:0]     eff_n;
    logic                 is_check, is_alloc, is_free, is_find;
    logic [ROW_W-1:0]     idx_row, p_row;
    logic [OFF_W-1:0]     idx_off, p_off;
    logic                 idx_bit;
    logic [CNT_W-1:0]     p;
    logic [CNT_W-1:0]     base, rem;
    logic [WORD_BITS-1:0] cand;
    logic [CNT_W-1:0]     hit_off;
    logic [CNT_W-1:0]     hit_pos;
    logic                 hit, last;
    logic                 write_ok;
    logic                 mem_we, mem_re;
    logic [ROW_W-1:0]     waddr, raddr;
    logic [WORD_BITS-1:0] wdata, idx_mask;

    assign eff_n = (int'(block_count) < int'(MAX_BLOCKS)) ? block_count : CNT_W'(MAX_BLOCKS);

    assign is_check = (kind_reg == KIND_CHECK);
    assign is_alloc = (kind_reg == KIND_ALLOC);
    assign is_free  = (kind_reg == KIND_FREE);
    assign is_find  = (kind_reg == KIND_FIND);

    assign idx_row  = ROW_W'(idx_reg >> LOG_W);
    assign idx_off  = OFF_W'(idx_reg & OFF_MASK);
    assign idx_bit  = rdata_reg[idx_off];
    assign idx_mask = WORD_BITS'(1) << idx_off;

    // Allocation rescans from the next block, find from its start index
    assign p     = is_alloc ? (idx_reg + CNT_W'(1)) : start_reg;
    assign p_row = ROW_W'(p >> LOG_W);
    assign p_off = OFF_W'(p & OFF_MASK);

    // Row under evaluation: base block and blocks left before n
    assign base = CNT_W'(scan_row_reg) << LOG_W;
    assign rem  = n_reg - base;
    assign last = (rem <= WORD_SPAN);

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            cand[b] = !rdata_reg[b] && (CNT_W'(b) < rem)
                      && (!first_reg || (b >= int'(off0_reg)));
        end
    end

    // Lowest free candidate in the row
    always_comb
    begin
        hit_off = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                hit_off = CNT_W'(b);
            end
        end
    end

    assign hit     = |cand;
    assign hit_pos = base + hit_off;

    assign write_ok = (is_alloc && !idx_bit) || (is_free && idx_bit);

    always_comb
    begin
        stat.is_format  = (kind_reg == KIND_FORMAT);
        stat.is_find    = is_find;
        stat.is_map_op  = is_check || is_alloc || is_free;
        stat.range_bad  = (is_check || is_alloc || is_free) ? (idx_reg >= n_reg)
                        : is_find ? (start_reg > n_reg) : 1'b0;
        stat.need_scan  = is_alloc && !idx_bit && (!hint_ok_reg || (hint_reg == idx_reg));
        stat.scan_empty = (p >= n_reg);
        stat.scan_end   = hit || last;
        stat.clr_last   = (clr_row_reg == ROW_W'(ROWS - 1));
    end

    // Memory port control
    always_comb
    begin
        mem_we = cmd.clr_step || (cmd.examine && write_ok);
        waddr  = cmd.clr_step ? clr_row_reg : idx_row;
        wdata  = cmd.clr_step ? '0
               : (is_alloc ? (rdata_reg | idx_mask) : (rdata_reg & ~idx_mask));
        mem_re = cmd.decode || cmd.scan_init || cmd.scan_step;
        priority if (cmd.decode)
        begin
            raddr = idx_row;
        end
        else if (cmd.scan_init)
        begin
            raddr = p_row;
        end
        else
        begin
            raddr = scan_row_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[waddr] <= wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= map_mem[raddr];
        end
    end

    // Request latch
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg  <= req_kind;
            idx_reg   <= CNT_W'(req_block_index);
            start_reg <= req_search_start;
            n_reg     <= eff_n;
        end
    end

    always_comb
    begin
        free_next     = free_reg;
        hint_next     = hint_reg;
        hint_ok_next  = hint_ok_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        fvalid_next   = fvalid_reg;
        scan_row_next = scan_row_reg;
        first_next    = first_reg;
        off0_next     = off0_reg;
        clr_row_next  = clr_row_reg;

        if (cmd.accept)
        begin
            status_next = STAT_OK;
            found_next  = '0;
            fvalid_next = 1'b0;
        end

        if (cmd.range_err)
        begin
            status_next = STAT_RANGE;
        end

        if (cmd.fmt_start)
        begin
            free_next    = n_reg;
            hint_next    = '0;
            hint_ok_next = (n_reg != '0);
            clr_row_next = '0;
        end

        if (cmd.clr_step)
        begin
            clr_row_next = clr_row_reg + ROW_W'(1);
        end

        if (cmd.examine)
        begin
            if (is_check)
            begin
                status_next = idx_bit ? STAT_OK : STAT_NOT_ALLOC;
            end
            else if (is_alloc)
            begin
                if (idx_bit)
                begin
                    status_next = STAT_IN_USE;
                end
                else if (free_reg != '0)
                begin
                    free_next = free_reg - CNT_W'(1);
                end
            end
            else if (is_free)
            begin
                if (!idx_bit)
                begin
                    status_next = STAT_NOT_ALLOC;
                end
                else
                begin
                    if (free_reg != CNT_SAT)
                    begin
                        free_next = free_reg + CNT_W'(1);
                    end
                    if (!hint_ok_reg || (hint_reg > idx_reg))
                    begin
                        hint_next    = idx_reg;
                        hint_ok_next = 1'b1;
                    end
                end
            end
        end

        if (cmd.scan_init)
        begin
            scan_row_next = p_row;
            off0_next     = p_off;
            first_next    = 1'b1;
            if (p >= n_reg)
            begin
                // nothing to examine: record a miss
                if (is_alloc)
                begin
                    hint_next    = '0;
                    hint_ok_next = 1'b0;
                end
            end
        end

        if (cmd.scan_step)
        begin
            scan_row_next = scan_row_reg + ROW_W'(1);
            first_next    = 1'b0;
            if (hit || last)
            begin
                if (is_find)
                begin
                    found_next  = hit ? hit_pos : '0;
                    fvalid_next = hit;
                end
                else
                begin
                    hint_next    = hit ? hit_pos : '0;
                    hint_ok_next = hit;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg    <= RST_FREE;
            hint_reg    <= '0;
            hint_ok_reg <= 1'b1;
            clr_row_reg <= '0;
        end
        else
        begin
            free_reg    <= free_next;
            hint_reg    <= hint_next;
            hint_ok_reg <= hint_ok_next;
            clr_row_reg <= clr_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        found_reg    <= found_next;
        fvalid_reg   <= fvalid_next;
        scan_row_reg <= scan_row_next;
        first_reg    <= first_next;
        off0_reg     <= off0_next;
    end

    // Response register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status          <= status_reg;
            found_block     <= IDX_W'(found_reg);
            found_valid     <= fvalid_reg;
            free_total      <= free_reg;
            first_free_hint <= hint_ok_reg ? IDX_W'(hint_reg) : '0;
            hint_valid      <= hint_ok_reg;
        end
    end

endmodule

`default_nettype wire

@@ sv/bab_ctrl.sv @@
// Controller of the block allocation bitmap: sequences clear sweeps, map accesses
// and scans, and owns both handshakes. Depends on bab_pkg.
`default_nettype none

module bab_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    input  wire bab_pkg::bab_stat_t stat,
    output bab_pkg::bab_cmd_t       cmd
);
    import bab_pkg::*;

    localparam logic [2:0] S_RST_CLR    = 3'd0;
    localparam logic [2:0] S_IDLE       = 3'd1;
    localparam logic [2:0] S_DECODE     = 3'd2;
    localparam logic [2:0] S_EXAMINE    = 3'd3;
    localparam logic [2:0] S_SCAN_START = 3'd4;
    localparam logic [2:0] S_SCAN       = 3'd5;
    localparam logic [2:0] S_FMT_CLR    = 3'd6;
    localparam logic [2:0] S_DONE       = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        cmd            = '0;

        unique case (state_reg)
            S_RST_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                priority if (stat.is_format)
                begin
                    cmd.fmt_start = 1'b1;
                    state_next    = S_FMT_CLR;
                end
                else if (stat.range_bad)
                begin
                    cmd.range_err = 1'b1;
                    state_next    = S_DONE;
                end
                else if (stat.is_map_op)
                begin
                    state_next = S_EXAMINE;
                end
                else if (stat.is_find)
                begin
                    state_next = S_SCAN_START;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_EXAMINE:
            begin
                cmd.examine = 1'b1;
                state_next  = stat.need_scan ? S_SCAN_START : S_DONE;
            end
            S_SCAN_START:
            begin
                cmd.scan_init = 1'b1;
                state_next    = stat.scan_empty ? S_DONE : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_FMT_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the response register is free
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RST_CLR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/block_allocation_bitmap.sv @@
// Top level of the block allocation bitmap: block_count register, controller and
// datapath. Depends on bab_pkg, bab_if, bab_ctrl and bab_datapath.
//
// Usage
//   req carries one request (kind, block_index, search_start); rsp returns exactly
//   one response per request, in order. cfg_we/cfg_wdata write block_count; write
//   it only while no request is in flight. The block serves one request at a time.
//   Each map row is W bits wide (SCAN_WORD_BITS rounded up to a power of two), and
//   the map holds R = ceil(MAX_BLOCKS / W) rows. Find scans the map; allocate
//   rescans it only when it takes the hinted block or has no valid hint. A scan
//   evaluates one map row per cycle while the next row is read; format zeroes all
//   R rows, one map row per cycle. After reset a sweep clears the map while
//   req.ready stays low; block_count returns to 1024.
//   The response sits in an output register; while rsp.ready is low it holds, and
//   a new request is still taken and worked on until its result needs that register.
`default_nettype none

module block_allocation_bitmap #(
    parameter int unsigned MAX_BLOCKS     = bab_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned SCAN_WORD_BITS = bab_pkg::SCAN_WORD_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [bab_pkg::CNT_W-1:0] cfg_wdata,
    bab_req_if.sink                        req,
    bab_rsp_if.source                      rsp
);
    import bab_pkg::*;

    logic [CNT_W-1:0] block_count_reg;
    bab_cmd_t         cmd;
    bab_stat_t        stat;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= BLOCK_COUNT_RST;
        end
        else if (cfg_we)
        begin
            block_count_reg <= cfg_wdata;
        end
    end

    bab_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bab_datapath #(
        .MAX_BLOCKS     (MAX_BLOCKS),
        .SCAN_WORD_BITS (SCAN_WORD_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .block_count      (block_count_reg),
        .req_kind         (req.kind),
        .req_block_index  (req.block_index),
        .req_search_start (req.search_start),
        .cmd              (cmd),
        .stat             (stat),
        .status           (rsp.status),
        .found_block      (rsp.found_block),
        .found_valid      (rsp.found_valid),
        .free_total       (rsp.free_total),
        .first_free_hint  (rsp.first_free_hint),
        .hint_valid       (rsp.hint_valid)
    );

    // One request at a time: an accepted request closes the input for the next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while another is in progress");

    // A found block is only reported with an ok status
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.found_valid |-> rsp.status == STAT_OK)
        else $error("found block reported with error status");

    // Without a valid hint the hint field reads zero
    a_hint_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.hint_valid |-> rsp.first_free_hint == '0)
        else $error("hint field nonzero while hint is invalid");

endmodule

`default_nettype wire

@@ bench/tb_block_allocation_bitmap.sv @@
// Testbench for block_allocation_bitmap: directed and random requests checked against a
// shadow allocation map kept in the bench. Depends on bab_pkg, bab_if and the RTL.
module tb_block_allocation_bitmap;
    timeunit 1ns;
    timeprecision 1ps;

    import bab_pkg::*;

    // Kinds the block ignores; it still answers them with the current totals.
    localparam kind_t KIND_UNUSED_LO = 3'd5;
    localparam kind_t KIND_UNUSED_HI = 3'd7;

    // Generous bound, several times what the slowest legal run needs.
    localparam int CYCLE_LIMIT = 600000;
    localparam int SEG_COUNT   = 7;

    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] found_block;
        logic             found_valid;
        logic [CNT_W-1:0] free_total;
        logic [IDX_W-1:0] hint;
        logic             hint_valid;
    } bitmap_rsp_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    bab_req_if req();
    bab_rsp_if rsp();

    block_allocation_bitmap u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    // 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow copy of the block state and of the block_count register.
    bit [MAX_BLOCKS_DEF-1:0] shadow_map;
    logic [CNT_W-1:0]        shadow_free;
    logic [IDX_W-1:0]        shadow_hint;
    bit                      shadow_hint_ok;
    logic [CNT_W-1:0]        shadow_blocks;

    // Responses still owed by the block, oldest first.
    bitmap_rsp_t awaited_rsp[$];

    int mismatches  = 0;
    int rsp_checked = 0;
    int cycles      = 0;
    int kind_seen[8];
    int unused_seen = 0;
    int src_gap_pct = 9;
    int snk_gap_pct = 73;

    // Random traffic is split into segments, one block_count setting each.
    int seg_blocks[SEG_COUNT] = '{1024, 40, 8, 2047, 1, 0, 130};
    int seg_items[SEG_COUNT]  = '{140, 110, 80, 40, 25, 10, 30};

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------

    // Blocks actually managed: the register clipped to the map size.
    function automatic int unsigned eff_blocks();
        return (shadow_blocks < MAX_BLOCKS_DEF) ? int'(shadow_blocks) : MAX_BLOCKS_DEF;
    endfunction

    // First free block in [from, n), or -1 when there is none.
    function automatic int first_free_from(int unsigned from, int unsigned n);
        for (int unsigned i = from; i < n; i++)
            if (!shadow_map[i])
                return int'(i);
        return -1;
    endfunction

    // Format uses the block_count of the moment.
    function automatic void format_shadow();
        int unsigned n;
        n              = eff_blocks();
        shadow_map     = '0;
        shadow_free    = CNT_W'(n);
        shadow_hint    = '0;
        shadow_hint_ok = (n > 0);
    endfunction

    // Apply one accepted request to the shadow state and return the response it owes.
    function automatic bitmap_rsp_t apply_to_shadow_map(kind_t k, logic [IDX_W-1:0] idx,
                                                        logic [CNT_W-1:0] start);
        bitmap_rsp_t r;
        int unsigned n;
        int          pos;
        r = '0;
        n = eff_blocks();
        case (k)
            KIND_FORMAT:
                format_shadow();
            KIND_CHECK:
                if (idx >= n)
                    r.status = STAT_RANGE;
                else if (!shadow_map[idx])
                    r.status = STAT_NOT_ALLOC;
            KIND_ALLOC:
                if (idx >= n)
                    r.status = STAT_RANGE;
                else if (shadow_map[idx])
                    r.status = STAT_IN_USE;
                else
                begin
                    shadow_map[idx] = 1'b1;
                    if (shadow_free != 0)
                        shadow_free = shadow_free - CNT_W'(1);
                    // Taking the hinted block, or having no hint, moves the hint forward.
                    if (!shadow_hint_ok || shadow_hint == idx)
                    begin
                        pos            = first_free_from(int'(idx) + 1, n);
                        shadow_hint_ok = (pos >= 0);
                        shadow_hint    = (pos >= 0) ? IDX_W'(pos) : '0;
                    end
                end
            KIND_FREE:
                if (idx >= n)
                    r.status = STAT_RANGE;
                else if (!shadow_map[idx])
                    r.status = STAT_NOT_ALLOC;     // double free: nothing counted
                else
                begin
                    shadow_map[idx] = 1'b0;
                    if (shadow_free != CNT_SAT)
                        shadow_free = shadow_free + CNT_W'(1);
                    if (!shadow_hint_ok || shadow_hint > idx)
                    begin
                        shadow_hint    = idx;
                        shadow_hint_ok = 1'b1;
                    end
                end
            KIND_FIND:
                if (start > n)
                    r.status = STAT_RANGE;
                else
                begin
                    pos = first_free_from(start, n);
                    if (pos >= 0)
                    begin
                        r.found_block = IDX_W'(pos);
                        r.found_valid = 1'b1;
                    end
                end
            default: ;
        endcase
        r.free_total = shadow_free;
        r.hint       = shadow_hint_ok ? shadow_hint : '0;
        r.hint_valid = shadow_hint_ok;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request, hold it until the block takes it, then record what it owes.
    task automatic send_request(input kind_t k, input logic [IDX_W-1:0] idx,
                                input logic [CNT_W-1:0] start);
        while ($urandom_range(0, 99) < src_gap_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.kind         <= k;
        req.block_index  <= idx;
        req.search_start <= start;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        awaited_rsp.push_back(apply_to_shadow_map(k, idx, start));
        kind_seen[k]++;
    endtask

    // Drop valid and wait until every owed response is back.
    task automatic wait_until_idle();
        req.valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write block_count, only ever with the block idle.
    task automatic write_block_count(input logic [CNT_W-1:0] value);
        wait_until_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we        <= 1'b0;
        shadow_blocks  = value;
    endtask

    // ------------------------------------------------------------------
    // Response side: pace ready and compare each response with the oldest owed one
    // ------------------------------------------------------------------

    function automatic void check_field(string what, logic [CNT_W-1:0] want,
                                        logic [CNT_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: response %0d %s expected %0d, got %0d",
                     $time, rsp_checked, what, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : rsp_check
        bitmap_rsp_t want;
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected response, expected none, got status %0d free %0d",
                             $time, rsp.status, rsp.free_total);
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    check_field("status", CNT_W'(want.status), CNT_W'(rsp.status));
                    check_field("found_block", CNT_W'(want.found_block),
                                CNT_W'(rsp.found_block));
                    check_field("found_valid", CNT_W'(want.found_valid),
                                CNT_W'(rsp.found_valid));
                    check_field("free_total", want.free_total, rsp.free_total);
                    check_field("first_free_hint", CNT_W'(want.hint),
                                CNT_W'(rsp.first_free_hint));
                    check_field("hint_valid", CNT_W'(want.hint_valid),
                                CNT_W'(rsp.hint_valid));
                    rsp_checked++;
                end
            end
            rsp.ready <= ($urandom_range(0, 99) >= snk_gap_pct);
        end
    end

    // Watchdog: a stuck handshake ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d responses outstanding", $time, awaited_rsp.size());
            $display("tb_block_allocation_bitmap: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Check, allocate, free and unused kinds at the default 1024 blocks, extreme indexes included.
    task automatic test_map_ops();
        send_request(KIND_CHECK, 10'd0, 11'd0);        // free block reads as not allocated
        send_request(KIND_ALLOC, 10'd0, 11'd0);        // hinted block: hint rescans to 1
        send_request(KIND_ALLOC, 10'd0, 11'd0);        // second allocate is refused
        send_request(KIND_CHECK, 10'd0, 11'd0);
        send_request(KIND_ALLOC, 10'd1023, 11'd0);     // top of the map
        send_request(KIND_FREE, 10'd1023, 11'd0);
        send_request(KIND_FREE, 10'd1023, 11'd0);      // double free, count must not move
        send_request(KIND_FREE, 10'd0, 11'd0);         // below the hint: hint drops to 0
        send_request(KIND_UNUSED_HI, 10'd1023, 11'd2047);
        send_request(KIND_UNUSED_LO, 10'd0, 11'd0);
    endtask

    // Find at the start bounds: start equal to n is legal and finds nothing.
    task automatic test_find_bounds();
        send_request(KIND_ALLOC, 10'd0, 11'd0);
        send_request(KIND_FIND, 10'd0, 11'd0);         // skips the used block 0
        send_request(KIND_FIND, 10'd0, 11'd1024);
        send_request(KIND_FIND, 10'd0, 11'd1025);      // one past n
        send_request(KIND_FIND, 10'd0, 11'd2047);
        send_request(KIND_FORMAT, 10'd0, 11'd0);
    endtask

    // Tiny and empty maps, block_count changes without a format, counter at zero.
    task automatic test_block_count_extremes();
        write_block_count(11'd2);
        send_request(KIND_ALLOC, 10'd0, 11'd0);
        send_request(KIND_ALLOC, 10'd1, 11'd0);        // rescan fails: hint goes invalid
        send_request(KIND_FIND, 10'd0, 11'd0);         // full map: ok, nothing found
        send_request(KIND_CHECK, 10'd2, 11'd0);        // index equal to n
        send_request(KIND_FREE, 10'd1023, 11'd0);
        write_block_count(11'd0);
        send_request(KIND_FORMAT, 10'd0, 11'd0);       // zero free blocks, no hint
        send_request(KIND_ALLOC, 10'd0, 11'd0);
        send_request(KIND_FIND, 10'd0, 11'd0);
        send_request(KIND_FIND, 10'd0, 11'd1);
        // Grow without a format: allocate with no hint, free count pinned at zero.
        write_block_count(11'd4);
        send_request(KIND_ALLOC, 10'd2, 11'd0);
        send_request(KIND_FREE, 10'd2, 11'd0);
        write_block_count(11'd2047);                   // clips to the full map
        send_request(KIND_FORMAT, 10'd0, 11'd0);
    endtask

    // Random requests over several block_count settings, at the given pacing.
    task automatic test_random_traffic(input int src_pct, input int snk_pct);
        int unsigned      n;
        int unsigned      roll;
        int unsigned      sel;
        int unsigned      base;
        int               done;
        kind_t            k;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] start;
        wait_until_idle();
        src_gap_pct = src_pct;
        snk_gap_pct = snk_pct;
        for (int s = 0; s < SEG_COUNT; s++)
        begin
            write_block_count(CNT_W'(seg_blocks[s]));
            // Half the time keep the old map, so counts can disagree with n.
            if ($urandom_range(0, 1))
                send_request(KIND_FORMAT, '0, '0);
            n    = eff_blocks();
            done = 0;
            while (done < seg_items[s])
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    k = KIND_FORMAT;
                else if (roll < 18)
                    k = KIND_CHECK;
                else if (roll < 50)
                    k = KIND_ALLOC;
                else if (roll < 75)
                    k = KIND_FREE;
                else if (roll < 95)
                    k = KIND_FIND;
                else
                    k = kind_t'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));

                // Mostly legal indexes, biased to the hint, to used blocks for free and
                // check, and to a low window on big maps so the map actually fills.
                sel = $urandom_range(0, 9);
                if (n == 0 || sel == 0)
                    idx = IDX_W'($urandom_range(0, 1023));
                else if (sel == 1)
                    idx = (n > 1021) ? 10'd1023 : IDX_W'(n + $urandom_range(0, 2));
                else if (sel <= 3 && shadow_hint_ok)
                    idx = shadow_hint;
                else if (k == KIND_FREE || k == KIND_CHECK)
                begin
                    base = $urandom_range(0, n - 1);
                    idx  = IDX_W'(base);
                    for (int unsigned j = 0; j < n; j++)
                        if (shadow_map[(base + j) % n])
                        begin
                            idx = IDX_W'((base + j) % n);
                            break;
                        end
                end
                else if (n > 64 && $urandom_range(0, 1))
                    idx = IDX_W'($urandom_range(0, 63));
                else
                    idx = IDX_W'($urandom_range(0, n - 1));

                sel = $urandom_range(0, 9);
                if (sel == 0)
                    start = CNT_W'($urandom_range(0, 2047));
                else if (sel == 1)
                    start = CNT_W'(n);
                else if (sel == 2)
                    start = CNT_W'(n + 1);
                else if (n > 64 && sel < 6)
                    start = CNT_W'($urandom_range(0, 63));
                else
                    start = CNT_W'($urandom_range(0, n));

                send_request(k, idx, start);
                if (k <= KIND_FIND)
                    done++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        req.valid        <= 1'b0;
        req.kind         <= KIND_FORMAT;
        req.block_index  <= '0;
        req.search_start <= '0;
        shadow_blocks     = BLOCK_COUNT_RST;
        format_shadow();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // The clearing sweep after reset holds req.ready low; the handshake absorbs it.
        test_map_ops();
        test_find_bounds();
        test_block_count_extremes();
        test_random_traffic(9, 73);
        test_random_traffic(73, 9);
        test_random_traffic(0, 0);

        wait_until_idle();
        repeat (40) @(posedge clk);

        for (int u = int'(KIND_UNUSED_LO); u <= int'(KIND_UNUSED_HI); u++)
            unused_seen += kind_seen[u];
        $display("covered %0d format, %0d check, %0d allocate, %0d free, %0d find, %0d unused",
                 kind_seen[KIND_FORMAT], kind_seen[KIND_CHECK], kind_seen[KIND_ALLOC],
                 kind_seen[KIND_FREE], kind_seen[KIND_FIND], unused_seen);
        $display("%0d responses compared, block_count 0 to 2047, three pacing modes",
                 rsp_checked);
        if (mismatches == 0)
            $display("tb_block_allocation_bitmap: clean");
        else
            $display("tb_block_allocation_bitmap: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/bab_pkg.sv
sv/bab_if.sv
sv/bab_datapath.sv
sv/bab_ctrl.sv
sv/block_allocation_bitmap.sv
bench/tb_block_allocation_bitmap.sv
